>>> rtl/core/swes_pkg.sv
// shared constants for the sliding window encoder speed block
`default_nettype none
package swes_pkg;

    // ring depth and derived index width
    localparam int WINDOW_DEPTH = 8;
    localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // speed scale, ticks per millisecond to ticks per second
    localparam int                 SCALE_W     = 10;
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 10'd1000;

    // quotient width: a magnitude of at most 2^31 times the scale fits in 41 bits
    localparam int QUOT_W    = 41;
    localparam int DIV_CNT_W = $clog2(QUOT_W);

    // configuration register map
    localparam int          CFG_ADDR_W          = 3;
    localparam logic        REG_UPDATE_PERIOD   = 1'b0;
    localparam logic [15:0] UPDATE_PERIOD_RESET = 16'd10;

endpackage
`default_nettype wire

>>> rtl/core/sliding_window_encoder_speed.sv
// top level of the sliding window encoder speed estimator
//
//  channel  | dir | fields (tdata / tuser)                     | handshake
//  ---------+-----+--------------------------------------------+-------------------
//  s_       | in  | tdata[31:0] now_ms, tdata[63:32] tick_count | tvalid/tready
//  m_       | out | tdata[31:0] speed_tps, tuser[0] updated     | tvalid/tready
//  apb      | in  | update_period_ms at byte address 0          | psel/penable/pready
//
// an accepted update runs slot read, checks, one multiply by the scale,
// 41 steps of the shared restoring divider, saturation and output load; unchanged ticks skip the multiply and divide.
// a beat that is too early or has a non-positive span skips straight to the output load.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register, so a stalled m_ side holds only the final step of the next beat.
// aresetn is synchronous; it clears the ring valid bits, so every slot reads zero.
`default_nettype none
module sliding_window_encoder_speed (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input beat: [31:0] now_ms, [63:32] tick_count
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [63:0]                     s_tdata,
    // result beat: [31:0] speed_tps
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [31:0]                          m_tdata,
    // result flag: [0] updated
    output logic [0:0]                           m_tuser,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [swes_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import swes_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } state_t;

    state_t state_reg;

    // ring storage
    logic [31:0]             ring_times_mem [WINDOW_DEPTH];
    logic [31:0]             ring_ticks_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] ring_valid_reg;
    logic                    ring_we;

    // sequencer data
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  slot_reg;
    logic [PTR_W-1:0]  slot_next;
    logic [31:0]       now_reg;
    logic [31:0]       ticks_reg;
    logic [31:0]       rd_time_reg;
    logic [31:0]       rd_ticks_reg;
    logic              rd_valid_reg;
    logic [31:0]       last_accept_reg;
    logic [31:0]       held_speed_reg;
    logic [31:0]       held_speed_next;
    logic [15:0]       period_reg;
    logic              updated_reg;
    logic              neg_reg;
    logic [31:0]       mag_reg;
    logic [30:0]       span_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [31:0]       rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    // output register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        out_load;

    // check-stage arithmetic
    logic [31:0] ref_time;
    logic [31:0] ref_ticks;
    logic [31:0] since;
    logic [31:0] span;
    logic [31:0] dticks;
    logic        since_ok;
    logic        span_ok;

    // shared multiply and divide step
    logic [QUOT_W:0] prod_full;
    logic [31:0]     r_shift;
    logic [32:0]     r_diff;
    logic            r_ge;

    logic cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_UPDATE_PERIOD);
    assign prdata   = (paddr[CFG_ADDR_W-1] == REG_UPDATE_PERIOD) ? {16'd0, period_reg} : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a finished beat moves into the output register once it is free
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // oldest slot is the one after the current index
    assign slot_next = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    // slots never written read as zero
    assign ref_time  = rd_valid_reg ? rd_time_reg  : 32'd0;
    assign ref_ticks = rd_valid_reg ? rd_ticks_reg : 32'd0;
    assign since     = now_reg - last_accept_reg;
    assign span      = now_reg - ref_time;
    assign dticks    = ticks_reg - ref_ticks;
    assign since_ok  = !since[31] && (since[30:0] >= {15'd0, period_reg});
    assign span_ok   = !span[31] && (span != 32'd0);

    assign prod_full = (QUOT_W + 1)'(mag_reg) * (QUOT_W + 1)'(SPEED_SCALE);

    // restoring divide step
    assign r_shift = {rem_reg[30:0], quot_reg[QUOT_W-1]};
    assign r_diff  = {1'b0, r_shift} - {2'b00, span_reg};
    assign r_ge    = !r_diff[32];

    assign ring_we = (state_reg == ST_SAT);

    // truncated quotient with sign, saturated to 32 bits
    always_comb begin
        if (neg_reg) begin
            if ((|quot_reg[QUOT_W-1:32]) || (quot_reg[31] && (|quot_reg[30:0]))) begin
                held_speed_next = 32'h8000_0000;
            end else begin
                held_speed_next = 32'd0 - quot_reg[31:0];
            end
        end else begin
            if (|quot_reg[QUOT_W-1:31]) begin
                held_speed_next = 32'h7fff_ffff;
            end else begin
                held_speed_next = quot_reg[31:0];
            end
        end
    end

    // ring memory write and registered read
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_times_mem[slot_reg] <= now_reg;
            ring_ticks_mem[slot_reg] <= ticks_reg;
        end
        rd_time_reg  <= ring_times_mem[slot_reg];
        rd_ticks_reg <= ring_ticks_mem[slot_reg];
    end

    // sequencer, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ring_valid_reg  <= '0;
            ptr_reg         <= '0;
            last_accept_reg <= 32'd0;
            held_speed_reg  <= 32'd0;
            period_reg      <= UPDATE_PERIOD_RESET;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                period_reg <= pwdata[15:0];
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        now_reg   <= s_tdata[31:0];
                        ticks_reg <= s_tdata[63:32];
                        slot_reg  <= slot_next;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    rd_valid_reg <= ring_valid_reg[slot_reg];
                    state_reg    <= ST_CHECK;
                end
                ST_CHECK: begin
                    neg_reg  <= dticks[31];
                    mag_reg  <= dticks[31] ? 32'd0 - dticks : dticks;
                    span_reg <= span[30:0];
                    if (!(since_ok && span_ok)) begin
                        updated_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end else if (dticks == 32'd0) begin
                        // unchanged ticks give zero speed
                        quot_reg  <= '0;
                        state_reg <= ST_SAT;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    quot_reg  <= prod_full[QUOT_W-1:0];
                    rem_reg   <= 32'd0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= r_ge ? r_diff[31:0] : r_shift;
                    quot_reg <= {quot_reg[QUOT_W-2:0], r_ge};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_CNT_W'(QUOT_W - 1)) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    // commit the sample; memory write happens alongside
                    held_speed_reg           <= held_speed_next;
                    ring_valid_reg[slot_reg] <= 1'b1;
                    ptr_reg                  <= slot_reg;
                    last_accept_reg          <= now_reg;
                    updated_reg              <= 1'b1;
                    state_reg                <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_tdata_reg  <= held_speed_reg;
                        m_tuser_reg  <= updated_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> tb/sv/tb_sliding_window_encoder_speed.sv
// self-checking testbench for the sliding window encoder speed estimator
module tb_sliding_window_encoder_speed;
    timeunit 1ns;
    timeprecision 1ps;

    import swes_pkg::*;

    // register byte addresses and run limits
    localparam logic [CFG_ADDR_W-1:0] ADDR_UPDATE_PERIOD = CFG_ADDR_W'(4 * REG_UPDATE_PERIOD);
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE         = CFG_ADDR_W'(4);
    localparam logic signed [31:0]    SPEED_MAX          = 32'sh7fff_ffff;
    localparam logic signed [31:0]    SPEED_MIN          = 32'sh8000_0000;
    localparam int                    CYCLE_LIMIT        = 600_000;
    localparam int                    DRAIN_CYCLES       = 60;
    localparam int                    PHASES             = 8;
    localparam int                    BEATS_PER_PHASE    = 116;
    localparam int                    DIRECTED_ROWS      = 23;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic        updated;
        logic [31:0] speed;
    } speed_result_t;

    // one directed beat, with an optional period change before it
    typedef struct {
        logic        sets_period;
        logic [15:0] period;
        logic [31:0] now;
        logic [31:0] ticks;
        logic        typed;
        logic        upd;
        logic [31:0] speed;
    } probe_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr  = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // model state of the estimator
    logic [31:0]        ring_time [WINDOW_DEPTH];
    logic [31:0]        ring_tick [WINDOW_DEPTH];
    logic [PTR_W-1:0]   ring_ptr;
    logic [31:0]        last_accept_ms;
    logic signed [31:0] held_speed;
    logic [15:0]        min_period_ms;

    speed_result_t pending_speeds[$];
    idle_mode_t    idle_mode   = IDLE_NONE;
    int            fault_count = 0;
    int            cycle_count = 0;
    logic [31:0]   stamp_ms;
    logic [31:0]   tick_now;

    probe_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 16'd0, 32'd0,          32'd5,          1'b1, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd10,         32'd0,          1'b1, 1'b1, 32'd0},
        '{1'b0, 16'd0, 32'd19,         32'd7,          1'b1, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd20,         32'h7fff_ffff,  1'b1, 1'b1, 32'h7fff_ffff},
        '{1'b0, 16'd0, 32'd30,         32'h8000_0000,  1'b1, 1'b1, 32'h8000_0000},
        '{1'b0, 16'd0, 32'd29,         32'd3,          1'b1, 1'b0, 32'h8000_0000},
        '{1'b0, 16'd0, 32'hffff_ffff,  32'd0,          1'b1, 1'b0, 32'h8000_0000},
        '{1'b0, 16'd0, 32'h8000_0000,  32'd1,          1'b1, 1'b0, 32'h8000_0000},
        '{1'b0, 16'd0, 32'd40,         32'd1000,       1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd50,         32'd990,        1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd60,         32'hffff_fff9,  1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd70,         32'd12345,      1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd80,         32'hffff_cfc7,  1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd90,         32'd0,          1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'h7fff_ffff,  1'b0, 1'b0, 32'd0},
        '{1'b1, 16'd0, 32'd100,        32'd1,          1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'd2,          1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'd3,          1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'hffff_ffff,  1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'd55,         1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'd55,         1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'd0,          1'b0, 1'b0, 32'd0},
        '{1'b0, 16'd0, 32'd100,        32'd9,          1'b0, 1'b0, 32'd0}
    };

    sliding_window_encoder_speed dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] now_ms, [63:32] tick_count
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] speed_tps
        .m_tuser  (m_tuser),   // [0] updated
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sliding_window_encoder_speed NOT OK");
            $finish;
        end
    end

    function automatic int sender_gap_pct(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER: return 58;
            IDLE_BOTH:   return 10;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input idle_mode_t mode);
        case (mode)
            IDLE_RECEIVER: return 58;
            IDLE_BOTH:     return 10;
            default:       return 0;
        endcase
    endfunction

    // clear the model state to its reset values
    function automatic void clear_estimate();
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            ring_time[k] = '0;
            ring_tick[k] = '0;
        end
        ring_ptr       = '0;
        last_accept_ms = '0;
        held_speed     = '0;
        min_period_ms  = UPDATE_PERIOD_RESET;
    endfunction

    // advance the model by one sample and return the result it gives
    function automatic speed_result_t estimate_speed(input logic [31:0] now,
                                                     input logic [31:0] ticks);
        logic [PTR_W-1:0]   slot;
        logic signed [31:0] since;
        logic signed [31:0] span;
        logic signed [31:0] dticks;
        longint             quot;
        speed_result_t      res;
        res.updated = 1'b0;
        since = now - last_accept_ms;
        if (longint'(since) >= longint'(min_period_ms)) begin
            slot = (ring_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ring_ptr + 1'b1;
            span = now - ring_time[slot];
            // a window span that is zero or wrapped negative is rejected
            if (span > 0) begin
                dticks = ticks - ring_tick[slot];
                if (dticks == 0) begin
                    held_speed = '0;
                end else begin
                    quot = (longint'(dticks) * longint'(SPEED_SCALE)) / longint'(span);
                    if (quot > longint'(SPEED_MAX))
                        held_speed = SPEED_MAX;
                    else if (quot < longint'(SPEED_MIN))
                        held_speed = SPEED_MIN;
                    else
                        held_speed = 32'(quot);
                end
                ring_time[slot] = now;
                ring_tick[slot] = ticks;
                ring_ptr        = slot;
                last_accept_ms  = now;
                res.updated     = 1'b1;
            end
        end
        res.speed = held_speed;
        return res;
    endfunction

    // apb write: setup then access, then idle
    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_UPDATE_PERIOD)
            min_period_ms = value[15:0];
        @(posedge aclk);
    endtask

    // apb read of the period register, compared with the model
    task automatic check_period_register();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_UPDATE_PERIOD;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[15:0] !== min_period_ms) begin
            $error("update_period_ms: expected %0d, actual %0d", min_period_ms, prdata[15:0]);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // send one sample beat and queue its expected result once accepted
    task automatic send_sample(input logic [31:0] now, input logic [31:0] ticks,
                               input logic typed, input speed_result_t typed_result);
        int            gap;
        speed_result_t predicted;
        gap = 0;
        while ($urandom_range(99) < sender_gap_pct(idle_mode))
            gap++;
        // now and then a long pause so gaps also cover the busy window
        if (gap > 0 && $urandom_range(9) == 0)
            gap += $urandom_range(60, 1);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ticks, now};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predicted = estimate_speed(now, ticks);
        pending_speeds.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain_results();
        while (pending_speeds.size() != 0)
            @(posedge aclk);
    endtask

    // next time stamp: mostly on or after the period, with early, backward and wrapped steps
    task automatic step_time(input logic [15:0] period);
        int unsigned pick;
        logic [31:0] step;
        pick = $urandom_range(99);
        if (pick < 60)
            step = 32'(period) + $urandom_range((period >> 2) + 3, 0);
        else if (pick < 70)
            step = (period > 0) ? $urandom_range(period - 1, 0) : 32'd0;
        else if (pick < 76)
            step = 32'd0;
        else if (pick < 82)
            step = -32'($urandom_range(50, 1));
        else if (pick < 88)
            step = $urandom();
        else if (pick < 94)
            step = 32'h7fff_fff0 + $urandom_range(32, 0);
        else
            step = $urandom_range(3, 1);
        stamp_ms += step;
    endtask

    // next tick count: small moves, holds, full-range values and saturating jumps
    task automatic step_ticks();
        int unsigned pick;
        logic [31:0] jump;
        pick = $urandom_range(99);
        if (pick < 40)
            tick_now += 32'($urandom_range(4000, 0)) - 32'd2000;
        else if (pick < 55)
            tick_now = tick_now;
        else if (pick < 70)
            tick_now += 32'($urandom_range(6, 0)) - 32'd3;
        else if (pick < 80)
            tick_now = $urandom();
        else if (pick < 90) begin
            jump = $urandom_range(32'h7fff_ffff, 32'h0020_0000);
            tick_now = $urandom_range(1) ? tick_now + jump : tick_now - jump;
        end else begin
            case ($urandom_range(3))
                0:       tick_now = 32'h7fff_ffff;
                1:       tick_now = 32'h8000_0000;
                2:       tick_now = 32'hffff_ffff;
                default: tick_now = 32'h0000_0000;
            endcase
        end
    endtask

    // result check and receiver stalls
    always @(posedge aclk) begin : result_check
        speed_result_t want;
        if (m_tvalid && m_tready) begin
            if (pending_speeds.size() == 0) begin
                $error("result beat with no result expected: updated %0b speed_tps %0d",
                       m_tuser[0], $signed(m_tdata));
                fault_count++;
            end else begin
                want = pending_speeds.pop_front();
                if (m_tuser[0] !== want.updated) begin
                    $error("updated: expected %0b, actual %0b", want.updated, m_tuser[0]);
                    fault_count++;
                end
                if (m_tdata !== want.speed) begin
                    $error("speed_tps: expected %0d, actual %0d",
                           $signed(want.speed), $signed(m_tdata));
                    fault_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
    end

    // main sequence
    initial begin : stimulus
        logic [15:0]   period;
        speed_result_t typed_result;
        clear_estimate();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats from the table, starting at the reset period
        foreach (directed_rows[r]) begin
            if (directed_rows[r].sets_period) begin
                s_tvalid <= 1'b0;
                drain_results();
                write_register(ADDR_UPDATE_PERIOD, {16'h0, directed_rows[r].period});
            end
            typed_result.updated = directed_rows[r].upd;
            typed_result.speed   = directed_rows[r].speed;
            send_sample(directed_rows[r].now, directed_rows[r].ticks,
                        directed_rows[r].typed, typed_result);
        end
        stamp_ms = 32'd100;
        tick_now = 32'd9;

        // random phases, each with its own period and idling pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            s_tvalid <= 1'b0;
            drain_results();
            idle_mode = idle_mode_t'(ph % 4);
            case (ph)
                0:       period = 16'd1;
                1:       period = 16'd10;
                2:       period = 16'd0;
                3:       period = 16'hffff;
                4:       period = 16'd3;
                5:       period = 16'($urandom_range(16'hffff, 0));
                6:       period = 16'd2;
                default: period = 16'd250;
            endcase
            write_register(ADDR_UPDATE_PERIOD, {16'($urandom_range(16'hffff, 0)), period});
            // a write to an unmapped register must leave the period alone
            if (ph == 2)
                write_register(ADDR_SPARE, $urandom());
            check_period_register();
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // halfway through, hold off until every result is back
                if (n == BEATS_PER_PHASE / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    drain_results();
                end
                step_time(period);
                step_ticks();
                send_sample(stamp_ms, tick_now, 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0 && pending_speeds.size() == 0)
            $display("tb_sliding_window_encoder_speed OK");
        else
            $display("tb_sliding_window_encoder_speed NOT OK");
        $finish;
    end

endmodule
